### rtl/hhbf_pkg.sv
// ----------------------------------------------------------------------------
// hhbf_pkg
// Types, codes and match words for the HTTP header and body framer.
// ----------------------------------------------------------------------------
package hhbf_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  localparam int CL_LEN = 14;
  localparam int TE_LEN = 17;
  localparam int CH_LEN = 7;

  localparam logic [4:0] MATCH_FAIL = 5'd31;
  localparam logic [3:0] CHUNK_FAIL = 4'd8;

  // match words, left aligned, first character in the top byte
  localparam logic [8*TE_LEN-1:0] CL_WORD = {"Content-Length", 24'h0};
  localparam logic [8*TE_LEN-1:0] TE_WORD = "Transfer-Encoding";
  localparam logic [8*TE_LEN-1:0] CH_WORD = {"chunked", 80'h0};

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_VT    = 8'h0b;
  localparam logic [7:0] CHAR_FF    = 8'h0c;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_END   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_HEADERS  = 3'd0,
    PH_BODY_LEN = 3'd1,
    PH_BODY_EOF = 3'd2,
    PH_DONE     = 3'd3,
    PH_ERROR    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    LP_LEAD   = 3'd0,
    LP_DIGITS = 3'd1,
    LP_DONE   = 3'd2,
    LP_BAD    = 3'd3,
    LP_OVER   = 3'd4
  } len_parse_t;

  typedef enum logic [1:0] {
    VT_NONE     = 2'd0,
    VT_LENGTH   = 2'd1,
    VT_ENCODING = 2'd2
  } value_target_t;

  typedef enum logic [2:0] {
    TK_NAME        = 3'd0,
    TK_VALUE       = 3'd1,
    TK_HEADER_END  = 3'd2,
    TK_HEADERS_END = 3'd3,
    TK_BODY        = 3'd4,
    TK_ERROR       = 3'd5
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_INVALID    = 2'd1,
    ERR_EMPTY_NAME = 2'd2
  } error_code_t;

  function automatic logic word_hit(input logic [4:0] pos, input logic [7:0] b,
                                    input logic [8*TE_LEN-1:0] word, input int len);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < TE_LEN; i++) begin
      if (i < len && pos == 5'(i) && word[8*(TE_LEN-1-i) +: 8] == b) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

### rtl/http_header_body_framer_top.sv
// ----------------------------------------------------------------------------
// http_header_body_framer_top
// Tags HTTP header bytes as name or value bytes and frames the message body.
//
// Input channel in_*: one request per byte or event. in_tuser carries the
// action (start, byte, end of stream) and the method flag sampled at start;
// in_tdata carries the stream byte. Output channel out_*: at most one token
// per request; out_tuser carries the token kind and error code, out_tdata
// the byte, out_tlast the final body token or body end marker.
// Throughput is one request per cycle unless a token waits on a stalled
// output. A request goes into an input register; the header and body state
// and the result register update from it once the result register is free
// or being taken. The Content-Length accumulator (shift-add times ten) and
// the body down-counter set the longest path. When the receiver stalls with
// a token waiting, one more request is held in the input register and
// in_tready drops. Synchronous reset empties both registers and puts the
// parser in the header phase with body allowed.
// ----------------------------------------------------------------------------
module http_header_body_framer_top #(
  parameter int LENGTH_BITS = hhbf_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [2:0] in_tuser,   // [1:0] action, [2] method_allows_body
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] token_byte
  output logic [4:0] out_tuser,  // [2:0] token_kind, [4:3] error_code
  output logic       out_tlast
);
  import hhbf_pkg::*;

  localparam int AW = LENGTH_BITS + 4;

  logic                   in_valid_r;
  action_t                act_r;
  logic [7:0]             byte_r;
  logic                   mab_r;
  logic                   advance;

  phase_t                 phase_r, phase_nxt;
  logic                   in_value_r, in_value_nxt;
  logic                   lwn_r, lwn_nxt;
  logic                   nonempty_r, nonempty_nxt;
  logic [4:0]             lpos_r, lpos_nxt;
  logic [4:0]             epos_r, epos_nxt;
  value_target_t          vt_r, vt_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  len_parse_t             lp_r, lp_nxt;
  logic [3:0]             cpos_r, cpos_nxt;
  logic                   lseen_r, lseen_nxt;
  logic                   cseen_r, cseen_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [1:0]             skip_r, skip_nxt;
  logic                   allowed_r, allowed_nxt;

  logic                   res_valid;
  token_kind_t            res_kind;
  logic [7:0]             res_byte;
  error_code_t            res_err;
  logic                   res_last;

  logic                   out_valid_r;
  token_kind_t            out_kind_r;
  logic [7:0]             out_byte_r;
  error_code_t            out_err_r;
  logic                   out_last_r;

  logic                   is_digit;
  logic                   is_lead_ws;
  logic [AW-1:0]          acc_x10;
  logic                   acc_over;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   skip_hit;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  assign is_digit   = (byte_r >= CHAR_ZERO) && (byte_r <= CHAR_NINE);
  assign is_lead_ws = (byte_r == CHAR_SPACE) || (byte_r == CHAR_TAB) ||
                      (byte_r == CHAR_VT) || (byte_r == CHAR_FF);
  assign acc_x10    = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) +
                      {{(AW-4){1'b0}}, byte_r[3:0]};
  assign acc_over   = acc_x10[AW-1 -: 4] != 4'b0;
  assign rem_dec    = rem_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  assign skip_hit   = (skip_r != 2'd0) && ((byte_r == CHAR_CR) || (byte_r == CHAR_LF));

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      act_r  <= action_t'(in_tuser[1:0]);
      byte_r <= in_tdata;
      mab_r  <= in_tuser[2];
    end
  end

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    in_value_nxt = in_value_r;
    lwn_nxt      = lwn_r;
    nonempty_nxt = nonempty_r;
    lpos_nxt     = lpos_r;
    epos_nxt     = epos_r;
    vt_nxt       = vt_r;
    acc_nxt      = acc_r;
    lp_nxt       = lp_r;
    cpos_nxt     = cpos_r;
    lseen_nxt    = lseen_r;
    cseen_nxt    = cseen_r;
    rem_nxt      = rem_r;
    skip_nxt     = skip_r;
    allowed_nxt  = allowed_r;
    unique case (act_r)
      ACT_START: begin
        phase_nxt    = PH_HEADERS;
        in_value_nxt = 1'b0;
        lwn_nxt      = 1'b0;
        nonempty_nxt = 1'b0;
        lpos_nxt     = 5'd0;
        epos_nxt     = 5'd0;
        vt_nxt       = VT_NONE;
        acc_nxt      = '0;
        lp_nxt       = LP_LEAD;
        cpos_nxt     = 4'd0;
        lseen_nxt    = 1'b0;
        cseen_nxt    = 1'b0;
        rem_nxt      = '0;
        skip_nxt     = 2'd0;
        allowed_nxt  = mab_r;
      end
      ACT_BYTE: begin
        if (phase_r == PH_HEADERS) begin
          if (byte_r == CHAR_NUL) begin
            phase_nxt = PH_ERROR;
          end else if (byte_r == CHAR_CR) begin
            phase_nxt = phase_r;
          end else if (byte_r == CHAR_LF && lwn_r) begin
            skip_nxt = 2'd1;
            if (lseen_r) begin
              if ((lp_r == LP_DIGITS || lp_r == LP_DONE) && acc_r != '0) begin
                rem_nxt   = acc_r;
                phase_nxt = PH_BODY_LEN;
              end else begin
                phase_nxt = PH_DONE;
              end
            end else if (cseen_r || !allowed_r) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_BODY_EOF;
            end
          end else begin
            lwn_nxt = (byte_r == CHAR_LF);
            if (!in_value_r) begin
              if (byte_r == CHAR_COLON) begin
                if (!nonempty_r) begin
                  phase_nxt = PH_ERROR;
                end else begin
                  in_value_nxt = 1'b1;
                  vt_nxt       = VT_NONE;
                  if (lpos_r == 5'(CL_LEN)) begin
                    vt_nxt    = VT_LENGTH;
                    lseen_nxt = 1'b1;
                    acc_nxt   = '0;
                    lp_nxt    = LP_LEAD;
                  end else if (epos_r == 5'(TE_LEN)) begin
                    vt_nxt   = VT_ENCODING;
                    cpos_nxt = 4'd0;
                  end
                end
              end else begin
                nonempty_nxt = 1'b1;
                lpos_nxt = word_hit(lpos_r, byte_r, CL_WORD, CL_LEN) ? lpos_r + 5'd1
                                                                      : MATCH_FAIL;
                epos_nxt = word_hit(epos_r, byte_r, TE_WORD, TE_LEN) ? epos_r + 5'd1
                                                                      : MATCH_FAIL;
              end
            end else if (byte_r == CHAR_LF) begin
              if (vt_r == VT_ENCODING) begin
                cseen_nxt = (cpos_r == 4'(CH_LEN));
              end
              in_value_nxt = 1'b0;
              nonempty_nxt = 1'b0;
              vt_nxt       = VT_NONE;
              lpos_nxt     = 5'd0;
              epos_nxt     = 5'd0;
            end else if (vt_r == VT_LENGTH) begin
              if (lp_r == LP_LEAD) begin
                if (is_lead_ws) begin
                  lp_nxt = LP_LEAD;
                end else if (is_digit) begin
                  acc_nxt = {{(LENGTH_BITS-4){1'b0}}, byte_r[3:0]};
                  lp_nxt  = LP_DIGITS;
                end else begin
                  lp_nxt = LP_BAD;
                end
              end else if (lp_r == LP_DIGITS) begin
                if (!is_digit) begin
                  lp_nxt = LP_DONE;
                end else if (acc_over) begin
                  lp_nxt = LP_OVER;
                end else begin
                  acc_nxt = acc_x10[LENGTH_BITS-1:0];
                end
              end
            end else if (vt_r == VT_ENCODING) begin
              if (!(cpos_r == 4'd0 && byte_r == CHAR_SPACE)) begin
                cpos_nxt = word_hit({1'b0, cpos_r}, byte_r, CH_WORD, CH_LEN) ?
                           cpos_r + 4'd1 : CHUNK_FAIL;
              end
            end
          end
        end else if (phase_r == PH_BODY_LEN || phase_r == PH_BODY_EOF) begin
          if (byte_r == CHAR_NUL) begin
            phase_nxt = PH_DONE;
          end else if (skip_hit) begin
            skip_nxt = skip_r - 2'd1;
          end else begin
            skip_nxt = 2'd0;
            if (phase_r == PH_BODY_LEN) begin
              rem_nxt = rem_dec;
              if (rem_dec == '0) begin
                phase_nxt = PH_DONE;
              end
            end
          end
        end
      end
      ACT_END: begin
        if (phase_r == PH_HEADERS) begin
          phase_nxt = PH_ERROR;
        end else if (phase_r == PH_BODY_LEN || phase_r == PH_BODY_EOF) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // token for the held request
  always_comb begin
    res_valid = 1'b0;
    res_kind  = TK_NAME;
    res_byte  = 8'h00;
    res_err   = ERR_NONE;
    res_last  = 1'b0;
    unique case (act_r)
      ACT_BYTE: begin
        if (phase_r == PH_HEADERS) begin
          if (byte_r == CHAR_NUL) begin
            res_valid = 1'b1;
            res_kind  = TK_ERROR;
            res_err   = ERR_INVALID;
          end else if (byte_r == CHAR_CR) begin
            res_valid = 1'b0;
          end else if (byte_r == CHAR_LF && lwn_r) begin
            res_valid = 1'b1;
            res_kind  = TK_HEADERS_END;
          end else if (!in_value_r) begin
            if (byte_r == CHAR_COLON) begin
              if (!nonempty_r) begin
                res_valid = 1'b1;
                res_kind  = TK_ERROR;
                res_err   = ERR_EMPTY_NAME;
              end
            end else begin
              res_valid = 1'b1;
              res_kind  = TK_NAME;
              res_byte  = byte_r;
            end
          end else if (byte_r == CHAR_LF) begin
            res_valid = 1'b1;
            res_kind  = TK_HEADER_END;
          end else begin
            res_valid = 1'b1;
            res_kind  = TK_VALUE;
            res_byte  = byte_r;
          end
        end else if (phase_r == PH_BODY_LEN || phase_r == PH_BODY_EOF) begin
          if (byte_r == CHAR_NUL) begin
            res_valid = 1'b1;
            res_kind  = TK_BODY;
            res_last  = 1'b1;
          end else if (!skip_hit) begin
            res_valid = 1'b1;
            res_kind  = TK_BODY;
            res_byte  = byte_r;
            res_last  = (phase_r == PH_BODY_LEN) && (rem_dec == '0);
          end
        end
      end
      ACT_END: begin
        if (phase_r == PH_HEADERS) begin
          res_valid = 1'b1;
          res_kind  = TK_ERROR;
          res_err   = ERR_INVALID;
        end else if (phase_r == PH_BODY_LEN || phase_r == PH_BODY_EOF) begin
          res_valid = 1'b1;
          res_kind  = TK_BODY;
          res_last  = 1'b1;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADERS;
      in_value_r  <= 1'b0;
      lwn_r       <= 1'b0;
      nonempty_r  <= 1'b0;
      lpos_r      <= 5'd0;
      epos_r      <= 5'd0;
      vt_r        <= VT_NONE;
      acc_r       <= '0;
      lp_r        <= LP_LEAD;
      cpos_r      <= 4'd0;
      lseen_r     <= 1'b0;
      cseen_r     <= 1'b0;
      rem_r       <= '0;
      skip_r      <= 2'd0;
      allowed_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r    <= phase_nxt;
        in_value_r <= in_value_nxt;
        lwn_r      <= lwn_nxt;
        nonempty_r <= nonempty_nxt;
        lpos_r     <= lpos_nxt;
        epos_r     <= epos_nxt;
        vt_r       <= vt_nxt;
        acc_r      <= acc_nxt;
        lp_r       <= lp_nxt;
        cpos_r     <= cpos_nxt;
        lseen_r    <= lseen_nxt;
        cseen_r    <= cseen_nxt;
        rem_r      <= rem_nxt;
        skip_r     <= skip_nxt;
        allowed_r  <= allowed_nxt;
      end
      if (advance) begin
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_err_r  <= res_err;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_err_r, out_kind_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == TK_ERROR) == (out_err_r != ERR_NONE)))
    else $error("error code does not match token kind");

  a_last_body: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == TK_BODY))
    else $error("last set on a non-body token");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY_LEN) |-> (rem_r != '0))
    else $error("length body with zero bytes remaining");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |=> (in_valid_r && $stable(act_r)))
    else $error("held request lost during output stall");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && act_r == ACT_START) |=> (phase_r == PH_HEADERS && !out_valid_r))
    else $error("start request left parser out of header phase");
`endif

endmodule

### dv/tb_http_header_body_framer_top.sv
// ----------------------------------------------------------------------------
// tb_http_header_body_framer_top
// Self-checking bench for the HTTP header and body framer.
//
// A directed table covers reset state, field extremes, every action and the
// error paths. Fixed header texts then exercise length parsing, chunked
// detection and body framing. Random messages follow: mostly well-formed
// headers with random content and bodies, plus broken messages and raw noise.
// Every taken request runs through a local predictor. Each token on the
// output is compared with the oldest queued token, taken from the predictor
// or, for directed rows, from the table. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_http_header_body_framer_top;
  import hhbf_pkg::*;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  data;
    error_code_t err;
    logic        last;
  } token_t;

  typedef enum logic [1:0] {
    SRC_PREDICT = 2'd0,
    SRC_TABLE   = 2'd1,
    SRC_QUIET   = 2'd2
  } tok_src_t;

  typedef struct {
    action_t    act;
    logic [7:0] data;
    logic       mab;
    tok_src_t   src;
    token_t     tok;
  } stim_row_t;

  localparam token_t NO_TOK = '{TK_NAME, 8'h00, ERR_NONE, 1'b0};
  localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic [2:0] in_tuser = 3'b000;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [4:0] out_tuser;
  logic       out_tlast;

  http_header_body_framer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  token_t token_q [$];
  int     n_req = 0;
  int     n_msg = 0;
  int     n_tok = 0;
  int     n_body = 0;
  int     n_errtok = 0;
  int     n_fail = 0;
  int     gap_pct = 0;
  bit     idle_on = 1'b1;

  string cl_word = "Content-Length";
  string te_word = "Transfer-Encoding";
  string ch_word = "chunked";
  string lead_ws = " \t\v\f";

  // framer state
  phase_t        ph;
  logic          in_val, last_nl, name_nz, len_seen, ch_seen, body_ok;
  logic [4:0]    cl_pos, te_pos;
  value_target_t vt;
  logic [63:0]   len_acc, body_left;
  len_parse_t    lp;
  logic [3:0]    ch_pos;
  logic [1:0]    skip_cnt;

  stim_row_t dir_tab [0:27] = '{
    '{ACT_BYTE,  8'h0d, 1'b0, SRC_QUIET,   NO_TOK},
    '{ACT_BYTE,  8'h3a, 1'b1, SRC_TABLE,   '{TK_ERROR, 8'h00, ERR_EMPTY_NAME, 1'b0}},
    '{ACT_BYTE,  8'h78, 1'b0, SRC_QUIET,   NO_TOK},
    '{ACT_END,   8'h00, 1'b0, SRC_QUIET,   NO_TOK},
    '{ACT_NONE,  8'hff, 1'b1, SRC_QUIET,   NO_TOK},
    '{ACT_START, 8'ha5, 1'b1, SRC_QUIET,   NO_TOK},
    '{ACT_BYTE,  8'hff, 1'b0, SRC_TABLE,   '{TK_NAME, 8'hff, ERR_NONE, 1'b0}},
    '{ACT_BYTE,  8'h0a, 1'b1, SRC_TABLE,   '{TK_NAME, 8'h0a, ERR_NONE, 1'b0}},
    '{ACT_BYTE,  8'h3a, 1'b0, SRC_QUIET,   NO_TOK},
    '{ACT_BYTE,  8'h80, 1'b1, SRC_TABLE,   '{TK_VALUE, 8'h80, ERR_NONE, 1'b0}},
    '{ACT_BYTE,  8'h0a, 1'b0, SRC_TABLE,   '{TK_HEADER_END, 8'h00, ERR_NONE, 1'b0}},
    '{ACT_BYTE,  8'h0a, 1'b0, SRC_TABLE,   '{TK_HEADERS_END, 8'h00, ERR_NONE, 1'b0}},
    '{ACT_BYTE,  8'h0d, 1'b1, SRC_QUIET,   NO_TOK},
    '{ACT_BYTE,  8'h0a, 1'b0, SRC_PREDICT, NO_TOK},
    '{ACT_NONE,  8'h00, 1'b0, SRC_QUIET,   NO_TOK},
    '{ACT_BYTE,  8'h01, 1'b1, SRC_PREDICT, NO_TOK},
    '{ACT_BYTE,  8'h00, 1'b0, SRC_TABLE,   '{TK_BODY, 8'h00, ERR_NONE, 1'b1}},
    '{ACT_END,   8'hff, 1'b1, SRC_QUIET,   NO_TOK},
    '{ACT_START, 8'h00, 1'b0, SRC_QUIET,   NO_TOK},
    '{ACT_BYTE,  8'h00, 1'b1, SRC_TABLE,   '{TK_ERROR, 8'h00, ERR_INVALID, 1'b0}},
    '{ACT_START, 8'hff, 1'b0, SRC_QUIET,   NO_TOK},
    '{ACT_BYTE,  8'h61, 1'b1, SRC_PREDICT, NO_TOK},
    '{ACT_END,   8'h00, 1'b0, SRC_TABLE,   '{TK_ERROR, 8'h00, ERR_INVALID, 1'b0}},
    '{ACT_START, 8'h00, 1'b1, SRC_QUIET,   NO_TOK},
    '{ACT_BYTE,  8'h0a, 1'b0, SRC_PREDICT, NO_TOK},
    '{ACT_BYTE,  8'h0a, 1'b1, SRC_TABLE,   '{TK_HEADERS_END, 8'h00, ERR_NONE, 1'b0}},
    '{ACT_BYTE,  8'h7f, 1'b0, SRC_PREDICT, NO_TOK},
    '{ACT_END,   8'h00, 1'b1, SRC_TABLE,   '{TK_BODY, 8'h00, ERR_NONE, 1'b1}}
  };

  string seed_hdr [0:7] = '{
    "Content-Length: \t\v\f12\n\n",
    "Content-Length: 4294967296\n\n",
    "Content-Length: -5\n\n",
    "Content-Length:4294967295\r\n\r\n",
    "Transfer-Encoding:   chunked\n\n",
    "Content-Length: 0\n\n",
    "Content-Length: 7x\nContent-Length: 3\n\n\r\n",
    "Host: a\n\n"
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #4_000_000;
    $display("http_header_body_framer_top test failed");
    $finish;
  end

  function automatic token_t tok(token_kind_t k, logic [7:0] d, error_code_t e, logic l);
    return '{k, d, e, l};
  endfunction

  function automatic void clear_parser();
    ph = PH_HEADERS;
    in_val = 1'b0; last_nl = 1'b0; name_nz = 1'b0;
    cl_pos = 5'd0; te_pos = 5'd0; vt = VT_NONE;
    len_acc = 64'd0; lp = LP_LEAD; ch_pos = 4'd0;
    len_seen = 1'b0; ch_seen = 1'b0; body_left = 64'd0; skip_cnt = 2'd0;
  endfunction

  function automatic logic [4:0] name_advance(logic [4:0] pos, string word, logic [7:0] b);
    if (int'(pos) < word.len() && word[int'(pos)] == b) return pos + 5'd1;
    return MATCH_FAIL;
  endfunction

  function automatic void length_char(logic [7:0] b);
    logic        is_dig;
    logic [63:0] d;
    is_dig = (b >= CHAR_ZERO && b <= CHAR_NINE);
    d = 64'(b - CHAR_ZERO) & 64'hf;
    case (lp)
      LP_LEAD: begin
        if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_VT || b == CHAR_FF) return;
        if (is_dig) begin
          len_acc = d;
          lp = LP_DIGITS;
        end else begin
          lp = LP_BAD;
        end
      end
      LP_DIGITS: begin
        if (!is_dig) lp = LP_DONE;
        else if (len_acc > (LEN_MAX - d) / 64'd10) lp = LP_OVER;
        else len_acc = len_acc * 64'd10 + d;
      end
      default: ;
    endcase
  endfunction

  function automatic void chunk_char(logic [7:0] b);
    if (ch_pos == 4'd0 && b == CHAR_SPACE) return;
    if (int'(ch_pos) < CH_LEN && ch_word[int'(ch_pos)] == b) ch_pos = ch_pos + 4'd1;
    else ch_pos = CHUNK_FAIL;
  endfunction

  function automatic logic header_step(logic [7:0] b, output token_t t);
    t = NO_TOK;
    if (b == CHAR_NUL) begin
      ph = PH_ERROR;
      t = tok(TK_ERROR, 8'h00, ERR_INVALID, 1'b0);
      return 1'b1;
    end
    if (b == CHAR_CR) return 1'b0;
    if (b == CHAR_LF && last_nl) begin
      skip_cnt = 2'd1;
      if (len_seen) begin
        if ((lp == LP_DIGITS || lp == LP_DONE) && len_acc != 64'd0) begin
          body_left = len_acc;
          ph = PH_BODY_LEN;
        end else begin
          ph = PH_DONE;
        end
      end else if (ch_seen || !body_ok) begin
        ph = PH_DONE;
      end else begin
        ph = PH_BODY_EOF;
      end
      t = tok(TK_HEADERS_END, 8'h00, ERR_NONE, 1'b0);
      return 1'b1;
    end
    last_nl = (b == CHAR_LF);
    if (!in_val) begin
      if (b == CHAR_COLON) begin
        if (!name_nz) begin
          ph = PH_ERROR;
          t = tok(TK_ERROR, 8'h00, ERR_EMPTY_NAME, 1'b0);
          return 1'b1;
        end
        in_val = 1'b1;
        vt = VT_NONE;
        if (cl_pos == 5'(CL_LEN)) begin
          vt = VT_LENGTH;
          len_seen = 1'b1;
          len_acc = 64'd0;
          lp = LP_LEAD;
        end else if (te_pos == 5'(TE_LEN)) begin
          vt = VT_ENCODING;
          ch_pos = 4'd0;
        end
        return 1'b0;
      end
      name_nz = 1'b1;
      cl_pos = name_advance(cl_pos, cl_word, b);
      te_pos = name_advance(te_pos, te_word, b);
      t = tok(TK_NAME, b, ERR_NONE, 1'b0);
      return 1'b1;
    end
    if (b == CHAR_LF) begin
      if (vt == VT_ENCODING) ch_seen = (ch_pos == 4'(CH_LEN));
      in_val = 1'b0; name_nz = 1'b0; vt = VT_NONE;
      cl_pos = 5'd0; te_pos = 5'd0;
      t = tok(TK_HEADER_END, 8'h00, ERR_NONE, 1'b0);
      return 1'b1;
    end
    if (vt == VT_LENGTH) length_char(b);
    else if (vt == VT_ENCODING) chunk_char(b);
    t = tok(TK_VALUE, b, ERR_NONE, 1'b0);
    return 1'b1;
  endfunction

  function automatic logic body_step(logic [7:0] b, output token_t t);
    t = NO_TOK;
    if (b == CHAR_NUL) begin
      ph = PH_DONE;
      t = tok(TK_BODY, 8'h00, ERR_NONE, 1'b1);
      return 1'b1;
    end
    if (skip_cnt != 2'd0) begin
      if (b == CHAR_CR || b == CHAR_LF) begin
        skip_cnt = skip_cnt - 2'd1;
        return 1'b0;
      end
      skip_cnt = 2'd0;
    end
    if (ph == PH_BODY_LEN) begin
      body_left = (body_left - 64'd1) & LEN_MAX;
      if (body_left == 64'd0) begin
        ph = PH_DONE;
        t = tok(TK_BODY, b, ERR_NONE, 1'b1);
        return 1'b1;
      end
    end
    t = tok(TK_BODY, b, ERR_NONE, 1'b0);
    return 1'b1;
  endfunction

  function automatic logic frame_step(action_t a, logic [7:0] b, logic mab, output token_t t);
    t = NO_TOK;
    case (a)
      ACT_START: begin
        clear_parser();
        body_ok = mab;
        return 1'b0;
      end
      ACT_BYTE: begin
        if (ph == PH_HEADERS) return header_step(b, t);
        if (ph == PH_BODY_LEN || ph == PH_BODY_EOF) return body_step(b, t);
        return 1'b0;
      end
      ACT_END: begin
        if (ph == PH_HEADERS) begin
          ph = PH_ERROR;
          t = tok(TK_ERROR, 8'h00, ERR_INVALID, 1'b0);
          return 1'b1;
        end
        if (ph == PH_BODY_LEN || ph == PH_BODY_EOF) begin
          ph = PH_DONE;
          t = tok(TK_BODY, 8'h00, ERR_NONE, 1'b1);
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_req(action_t a, logic [7:0] b, logic mab, tok_src_t src,
                          token_t typed);
    token_t t;
    logic   hit;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {mab, a};
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    hit = frame_step(a, b, mab, t);
    if (src == SRC_TABLE) token_q = {token_q, typed};
    else if (src == SRC_PREDICT && hit) token_q = {token_q, t};
    n_req++;
  endtask

  task automatic put_byte(logic [7:0] b);
    send_req(ACT_BYTE, b, 1'($urandom_range(0, 1)), SRC_PREDICT, NO_TOK);
  endtask

  task automatic put_start(logic mab);
    send_req(ACT_START, 8'($urandom_range(0, 255)), mab, SRC_PREDICT, NO_TOK);
  endtask

  task automatic put_end();
    send_req(ACT_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             SRC_PREDICT, NO_TOK);
  endtask

  task automatic put_text(string s, bit noisy);
    for (int i = 0; i < s.len(); i++) begin
      if (noisy && $urandom_range(0, 15) == 0) put_byte(CHAR_CR);
      put_byte(s[i]);
    end
  endtask

  task automatic drain_tokens();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  task automatic send_header(inout int want_len);
    string      nm, val;
    int         n;
    logic [7:0] c;
    val = "";
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        nm = "Content-Length";
        repeat ($urandom_range(0, 2)) val = $sformatf("%s%c", val, lead_ws[$urandom_range(0, 3)]);
        n = $urandom_range(0, 9);
        if (n <= 5) begin
          want_len = $urandom_range(1, 40);
          val = $sformatf("%s%0d", val, want_len);
        end else if (n == 6) begin
          want_len = 0;
          val = {val, "0"};
        end else if (n == 7) begin
          want_len = -1;
          val = {val, "+5"};
        end else if (n == 8) begin
          want_len = -1;
          val = {val, "4294967296"};
        end else begin
          want_len = -1;
          val = {val, "4294967295"};
        end
        if ($urandom_range(0, 3) == 0) val = {val, " ;q"};
      end
      3, 4: begin
        nm = "Transfer-Encoding";
        repeat ($urandom_range(0, 2)) val = {val, " "};
        case ($urandom_range(0, 5))
          0, 1, 2: val = {val, "chunked"};
          3:       val = {val, "chunke"};
          4:       val = {val, "chunkedx"};
          default: val = {val, "gzip"};
        endcase
      end
      5: begin
        case ($urandom_range(0, 3))
          0:       nm = "Content-Lengt";
          1:       nm = "content-length";
          2:       nm = "Transfer-Encodin";
          default: nm = "XContent-Length";
        endcase
        val = $sformatf(" %0d", $urandom_range(1, 9));
      end
      default: begin
        nm = "";
        repeat ($urandom_range(1, 8)) begin
          c = 8'($urandom_range(33, 126));
          if (c == CHAR_COLON) c = 8'h5a;
          if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(128, 255));
          nm = $sformatf("%s%c", nm, c);
        end
        repeat ($urandom_range(0, 10)) begin
          c = 8'($urandom_range(32, 126));
          if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(128, 255));
          if ($urandom_range(0, 15) == 0) c = CHAR_TAB;
          val = $sformatf("%s%c", val, c);
        end
      end
    endcase
    put_text(nm, 1'b1);
    put_byte(CHAR_COLON);
    put_text(val, 1'b1);
    if ($urandom_range(0, 1) == 1) put_byte(CHAR_CR);
    put_byte(CHAR_LF);
  endtask

  task automatic send_message();
    int want_len, n, k;
    want_len = -1;
    n_msg++;
    put_start(1'($urandom_range(0, 1)));
    n = $urandom_range(0, 4);
    repeat (n) send_header(want_len);
    case ($urandom_range(0, 11))
      0: begin
        put_byte(CHAR_NUL);
        put_text("ab\n\n", 1'b0);
        return;
      end
      1: begin
        put_end();
        put_byte(8'h41);
        return;
      end
      2: begin
        put_byte(CHAR_COLON);
        put_byte(CHAR_LF);
        return;
      end
      default: ;
    endcase
    if (n == 0) put_byte(CHAR_LF);
    if ($urandom_range(0, 1) == 1) put_byte(CHAR_CR);
    put_byte(CHAR_LF);
    repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    if (want_len > 0 && $urandom_range(0, 3) != 0) k = want_len - 1 + int'($urandom_range(0, 3));
    else k = $urandom_range(0, 20);
    repeat (k) put_byte(8'($urandom_range(1, 255)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: put_end();
      5, 6:          put_byte(CHAR_NUL);
      default:       ;
    endcase
  endtask

  task automatic send_noise();
    action_t    a;
    logic [7:0] b;
    n_msg++;
    put_start(1'($urandom_range(0, 1)));
    repeat ($urandom_range(4, 30)) begin
      a = ACT_BYTE;
      case ($urandom_range(0, 9))
        0:       a = ACT_END;
        1:       a = ACT_NONE;
        2:       a = ACT_START;
        default: ;
      endcase
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
        0:       b = CHAR_NUL;
        1:       b = CHAR_LF;
        2:       b = CHAR_COLON;
        3:       b = CHAR_CR;
        default: ;
      endcase
      send_req(a, b, 1'($urandom_range(0, 1)), SRC_PREDICT, NO_TOK);
    end
  endtask

  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    token_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[2:0], out_tdata, out_tuser[4:3], out_tlast};
      n_tok++;
      if (got.kind == TK_BODY) n_body++;
      if (got.kind == TK_ERROR) n_errtok++;
      if (token_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 20)
          $display("%0t: unexpected token kind=%0d byte=%h err=%0d last=%0b", $time,
                   got.kind, got.data, got.err, got.last);
      end else begin
        want = token_q.pop_front();
        if (got.kind !== want.kind || got.data !== want.data || got.err !== want.err ||
            got.last !== want.last) begin
          n_fail++;
          if (n_fail <= 20) begin
            $display("%0t: token mismatch exp kind=%0d byte=%h err=%0d last=%0b",
                     $time, want.kind, want.data, want.err, want.last);
            $display("%0t:                got kind=%0d byte=%h err=%0d last=%0b",
                     $time, got.kind, got.data, got.err, got.last);
          end
        end
      end
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    clear_parser();
    body_ok = 1'b1;
    while (!rst_n) @(posedge clk);
    gap_pct = 20;
    for (int i = 0; i < $size(dir_tab); i++)
      send_req(dir_tab[i].act, dir_tab[i].data, dir_tab[i].mab, dir_tab[i].src, dir_tab[i].tok);
    drain_tokens();
    for (int i = 0; i < $size(seed_hdr); i++) begin
      n_msg++;
      put_start(i != 7);
      put_text(seed_hdr[i], 1'b0);
      repeat (14) put_byte(8'($urandom_range(1, 255)));
      put_end();
    end
    while (n_req < 1700) begin
      idle_on = (n_req < 1450);
      gap_pct = idle_on ? 10 * $urandom_range(0, 3) : 0;
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_message();
      if (!held && n_req > 900) begin
        held = 1'b1;
        drain_tokens();
      end
    end
    drain_tokens();
    repeat (8) @(posedge clk);
    $display("Run: %0d requests in %0d messages, %0d tokens checked", n_req, n_msg, n_tok);
    $display("     %0d body tokens, %0d error tokens, %0d mismatches", n_body, n_errtok, n_fail);
    if (n_fail == 0) begin
      $display("http_header_body_framer_top test passed");
    end else begin
      $display("http_header_body_framer_top test failed");
    end
    $finish;
  end

endmodule
